[src/dfs_pkg.sv]
package dfs_pkg;

  localparam int CNT_W  = 21;
  localparam int OFF_W  = 20;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 64;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  // register index, taken from paddr[3]
  localparam logic REG_SEP_BYTES  = 1'b0;
  localparam logic REG_SEP_LENGTH = 1'b1;

  typedef struct packed {
    logic [OFF_W-1:0] field_offset;
    logic [CNT_W-1:0] field_length;
    logic [CNT_W-1:0] field_row;
    logic [CNT_W-1:0] field_column;
    logic             closes_line;
    logic [CNT_W-1:0] lines_so_far;
    logic [CNT_W-1:0] longest_so_far;
    logic [CNT_W-1:0] fields_so_far;
    logic             final_field;
  } out_word_t;

endpackage

[src/delimited_field_splitter.sv]
// delimited field splitter
// input channel: one text byte per word (in_text_byte, in_end_of_text) with
// in_valid/in_ready. result channel: one word per completed field, carrying
// offset, length, row, column and running totals, with out_valid/out_ready.
// the separator (up to MAX_SEPARATOR_BYTES bytes, first byte in bits 7:0) and
// its length are set through the apb port: separator at 0x0, length at 0x8.
// write them only while no text is in flight.
// a byte is taken into an input register, then the separator window compare
// and counter updates run into the result register, so a field word shows
// on out_valid once the byte that closes it has passed both registers.
// one byte per cycle is sustained while the receiver takes the field words;
// the state update of the counters and the byte window is the loop that sets that rate.
// if the receiver stalls, bytes that close no field keep flowing; a closing
// byte waits in the input register, and the input stalls after that one.
// reset (synchronous, rst_n low) empties both registers, clears all counters
// and loads a one-byte comma separator. after the end_of_text byte the text
// counters return to zero and the next byte starts a new text.
module delimited_field_splitter #(
  parameter int MAX_SEPARATOR_BYTES = 8,
  parameter int MAX_TEXT_BYTES      = 1048576
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_text_byte,
  input  logic                        in_end_of_text,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dfs_pkg::OFF_W-1:0]   out_field_offset,
  output logic [dfs_pkg::CNT_W-1:0]   out_field_length,
  output logic [dfs_pkg::CNT_W-1:0]   out_field_row,
  output logic [dfs_pkg::CNT_W-1:0]   out_field_column,
  output logic                        out_closes_line,
  output logic [dfs_pkg::CNT_W-1:0]   out_lines_so_far,
  output logic [dfs_pkg::CNT_W-1:0]   out_longest_so_far,
  output logic [dfs_pkg::CNT_W-1:0]   out_fields_so_far,
  output logic                        out_final_field,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dfs_pkg::ADDR_W-1:0]  paddr,
  input  logic [dfs_pkg::DATA_W-1:0]  pwdata,
  output logic [dfs_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import dfs_pkg::*;

  localparam int WIN_W     = 8 * MAX_SEPARATOR_BYTES;
  localparam int LIMIT_INT = (MAX_TEXT_BYTES < 1048576) ? MAX_TEXT_BYTES : 1048576;
  localparam logic [CNT_W-1:0] COUNT_LIMIT  = CNT_W'(LIMIT_INT);
  localparam logic [OFF_W-1:0] OFFSET_LIMIT = OFF_W'(LIMIT_INT - 1);
  localparam logic [3:0]       SEP_MAX      = 4'(MAX_SEPARATOR_BYTES);

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v >= COUNT_LIMIT) ? COUNT_LIMIT : v + CNT_W'(1);
  endfunction

  // configuration
  logic [63:0] sep_bytes_r;
  logic [3:0]  sep_len_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[3] == REG_SEP_LENGTH) ? {60'd0, sep_len_r} : sep_bytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_bytes_r <= 64'd44;
      sep_len_r   <= 4'd1;
    end else if (cfg_wr) begin
      if (paddr[3] == REG_SEP_BYTES) begin
        sep_bytes_r <= pwdata[63:0];
      end else begin
        sep_len_r <= pwdata[3:0];
      end
    end
  end

  // input register
  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_eot_r;
  logic       adv;

  assign in_ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_text_byte;
      in_eot_r  <= in_end_of_text;
    end
  end

  // text state
  logic [WIN_W-1:0] recent_r, recent_nxt;
  logic [CNT_W-1:0] bif_r, bif_nxt;
  logic [OFF_W-1:0] begin_r, begin_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] longest_r, longest_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;

  logic [WIN_W+7:0] win_full;
  logic [WIN_W-1:0] window;
  logic [3:0]       sep_n;
  logic             win_match;
  logic             is_nl, sep_hit, emit, closes;
  logic [CNT_W-1:0] next_pos, cnt, len;
  out_word_t        res;

  assign win_full = {recent_r, in_byte_r};
  assign window   = win_full[WIN_W-1:0];

  always_comb begin
    if (sep_len_r == 4'd0) begin
      sep_n = 4'd1;
    end else if (sep_len_r > SEP_MAX) begin
      sep_n = SEP_MAX;
    end else begin
      sep_n = sep_len_r;
    end
  end

  // compare the newest n bytes against the separator, for every possible n
  always_comb begin
    logic m;
    win_match = 1'b0;
    for (int k = 1; k <= MAX_SEPARATOR_BYTES; k++) begin
      m = 1'b1;
      for (int i = 0; i < k; i++) begin
        if (window[8*i +: 8] != sep_bytes_r[8*(k-1-i) +: 8]) m = 1'b0;
      end
      if (sep_n == 4'(k)) win_match = m;
    end
  end

  always_comb begin
    next_pos = sat_inc(pos_r);
    cnt      = sat_inc(bif_r);
    is_nl    = (in_byte_r == NEWLINE_BYTE);
    sep_hit  = !is_nl && (cnt >= {17'd0, sep_n}) && win_match;
    emit     = is_nl || sep_hit || in_eot_r;
    closes   = is_nl || !sep_hit;
    if (is_nl) begin
      len = bif_r;
    end else if (sep_hit) begin
      len = cnt - {17'd0, sep_n};
    end else begin
      len = cnt;
    end

    longest_nxt = (len > longest_r) ? len : longest_r;
    total_nxt   = sat_inc(total_r);
    row_nxt     = closes ? sat_inc(row_r) : row_r;
    col_nxt     = closes ? '0 : sat_inc(col_r);

    res.field_offset   = begin_r;
    res.field_length   = len;
    res.field_row      = row_r;
    res.field_column   = col_r;
    res.closes_line    = closes;
    res.lines_so_far   = row_nxt;
    res.longest_so_far = longest_nxt;
    res.fields_so_far  = total_nxt;
    res.final_field    = in_eot_r;

    recent_nxt = '0;
    bif_nxt    = '0;
    pos_nxt    = next_pos;
    begin_nxt  = (next_pos > {1'b0, OFFSET_LIMIT}) ? OFFSET_LIMIT : next_pos[OFF_W-1:0];
    if (!emit) begin
      recent_nxt  = window;
      bif_nxt     = cnt;
      begin_nxt   = begin_r;
      row_nxt     = row_r;
      col_nxt     = col_r;
      longest_nxt = longest_r;
      total_nxt   = total_r;
    end else if (in_eot_r) begin
      pos_nxt     = '0;
      begin_nxt   = '0;
      row_nxt     = '0;
      col_nxt     = '0;
      longest_nxt = '0;
      total_nxt   = '0;
    end
  end

  // output register
  logic      out_v_r;
  out_word_t out_r;

  // a byte that closes no field never waits for the receiver
  assign adv = in_v_r && (!emit || !out_v_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r  <= '0;
      bif_r     <= '0;
      begin_r   <= '0;
      pos_r     <= '0;
      row_r     <= '0;
      col_r     <= '0;
      longest_r <= '0;
      total_r   <= '0;
      out_v_r   <= 1'b0;
    end else begin
      if (adv) begin
        recent_r  <= recent_nxt;
        bif_r     <= bif_nxt;
        begin_r   <= begin_nxt;
        pos_r     <= pos_nxt;
        row_r     <= row_nxt;
        col_r     <= col_nxt;
        longest_r <= longest_nxt;
        total_r   <= total_nxt;
      end
      if (adv && emit) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_v_r;
  assign out_field_offset   = out_r.field_offset;
  assign out_field_length   = out_r.field_length;
  assign out_field_row      = out_r.field_row;
  assign out_field_column   = out_r.field_column;
  assign out_closes_line    = out_r.closes_line;
  assign out_lines_so_far   = out_r.lines_so_far;
  assign out_longest_so_far = out_r.longest_so_far;
  assign out_fields_so_far  = out_r.fields_so_far;
  assign out_final_field    = out_r.final_field;

`ifndef SYNTHESIS
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_r.fields_so_far != '0)
    else $error("field word with zero field count");

  a_longest_covers: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_r.longest_so_far >= out_r.field_length)
    else $error("longest field below current field length");

  a_lines_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_r.lines_so_far == out_r.field_row ||
                 out_r.lines_so_far == out_r.field_row + CNT_W'(1)))
    else $error("line count out of step with field row");

  a_text_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_eot_r) |=> (total_r == '0 && pos_r == '0 && bif_r == '0))
    else $error("text state not cleared after end of text");
`endif

endmodule
